### rtl/sif_pkg.sv
// Package for the set intersection filter.
// Holds item codes, controller states and the command and status structs.
// No dependencies.
package sif_pkg;

  // Default number of set entries.
  localparam int SET_DEPTH_DEF = 64;

  // Item kind codes.
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_PROBE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes.
  localparam logic STATUS_MATCH = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // Latch the incoming word and restart the scan.
    logic scan;        // Advance the entry scan by one read.
    logic hit_save;    // Remember the index of the matching entry.
    logic load_wr;     // Append the held value at the end of the set.
    logic move_rd;     // Read the last entry of the set.
    logic move_wr;     // Move the last entry into the freed slot.
    logic clear;       // Empty the set.
    logic out_load;    // Put a result word into the output register.
    logic out_status;  // Status of that result word.
  } sif_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       match;      // The entry compared this cycle holds the value.
    logic       scan_done;  // Every stored entry has been compared.
    logic       full;       // The set holds SET_DEPTH entries.
    logic       out_busy;   // A result word waits and is not taken this cycle.
    logic [1:0] kind;       // Kind of the held word.
  } sif_sts_t;

endpackage

### rtl/sif_item_if.sv
// Input channel of the set intersection filter: valid, ready and one item word.
// No dependencies.
interface sif_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic signed [31:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

### rtl/sif_result_if.sv
// Output channel of the set intersection filter: valid, ready and one result word.
// No dependencies.
interface sif_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_res;
  logic               status;

  modport source (output valid, value_res, status, input ready);
  modport sink   (input valid, value_res, status, output ready);
endinterface

### rtl/sif_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sif_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/sif_datapath.sv
// Datapath of the set intersection filter: entry RAM, fill count, scan
// counters, comparator and output register. Depends on sif_pkg and sif_ram.
module sif_datapath
  import sif_pkg::*;
#(
  parameter int SET_DEPTH = SET_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_value,
  input  sif_cmd_t           cmd,
  output sif_sts_t           sts,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] res_value,
  output logic               res_status
);

  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CW = $clog2(SET_DEPTH + 1);

  // The set is kept packed in entries 0 .. count-1.
  logic [CW-1:0]      count;
  logic [CW-1:0]      scan_idx;
  logic [AW-1:0]      cmp_idx;
  logic [AW-1:0]      hit_idx;
  logic               cmp_pending;
  logic [1:0]         item_kind;
  logic signed [31:0] item_value;

  logic [AW-1:0] last_idx;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  // Address and data selection for the entry RAM.
  always_comb begin
    last_idx  = AW'(count - CW'(1));
    ram_we    = cmd.load_wr | cmd.move_wr;
    ram_waddr = cmd.move_wr ? hit_idx : count[AW-1:0];
    ram_wdata = cmd.move_wr ? ram_rdata : item_value;
    ram_re    = cmd.scan | cmd.move_rd;
    ram_raddr = cmd.move_rd ? last_idx : scan_idx[AW-1:0];
  end

  sif_ram #(
    .WIDTH (32),
    .DEPTH (SET_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status toward the controller.
  always_comb begin
    sts.match     = cmp_pending && (ram_rdata == item_value);
    sts.scan_done = !cmp_pending && (scan_idx == count);
    sts.full      = (count == CW'(SET_DEPTH));
    sts.out_busy  = res_valid && !res_ready;
    sts.kind      = item_kind;
  end

  // Held word and scan counters. One entry is read per cycle and compared
  // in the cycle after.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_kind  <= in_kind;
      item_value <= in_value;
      scan_idx   <= '0;
    end else if (cmd.scan && (scan_idx < count)) begin
      scan_idx <= scan_idx + CW'(1);
      cmp_idx  <= scan_idx[AW-1:0];
    end
    if (cmd.hit_save) begin
      hit_idx <= cmp_idx;
    end
  end

  // Compare-pending flag and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pending <= 1'b0;
      count       <= '0;
    end else begin
      if (cmd.capture) begin
        cmp_pending <= 1'b0;
      end else if (cmd.scan) begin
        cmp_pending <= (scan_idx < count);
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.load_wr) begin
        count <= count + CW'(1);
      end else if (cmd.move_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // Output register; a new result is loaded only when the old one is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_value  <= item_value;
      res_status <= cmd.out_status;
    end
  end

endmodule

### rtl/sif_ctrl.sv
// Controller state machine of the set intersection filter.
// Depends on sif_pkg.
module sif_ctrl
  import sif_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  output logic       in_ready,
  input  sif_sts_t   sts,
  output sif_cmd_t   cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_kind)
            KIND_LOAD, KIND_PROBE: state_next = ST_SCAN;
            KIND_CLEAR:            cmd.clear  = 1'b1;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match) begin
          // A load of a value already present does nothing.
          if (sts.kind == KIND_PROBE) begin
            cmd.hit_save = 1'b1;
            state_next   = ST_MOVE_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (sts.scan_done) begin
          if ((sts.kind == KIND_LOAD) && sts.full) begin
            state_next = ST_OUT;
          end else begin
            cmd.load_wr = (sts.kind == KIND_LOAD);
            state_next  = ST_IDLE;
          end
        end
      end
      ST_MOVE_RD: begin
        cmd.move_rd = 1'b1;
        state_next  = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        // The last entry fills the hole left by the removed one.
        cmd.move_wr = 1'b1;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = (sts.kind == KIND_LOAD) ? STATUS_FULL : STATUS_MATCH;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/set_intersection_filter.sv
// Top level of the set intersection filter: controller plus datapath.
// Depends on sif_pkg, sif_item_if, sif_result_if, sif_ctrl and sif_datapath.
//
// The block holds a set of up to SET_DEPTH 32-bit values, packed in a RAM
// behind a fill count. A load word adds its value unless it is present; a
// probe word that finds its value emits it with status 0 and removes it; a
// load that finds the set full emits the value with status 1; a clear word
// empties the set. Words are handled one at a time, and the input is ready
// only while the controller is idle. A load or probe reads the n stored
// entries through the RAM read port, one per cycle, and compares each entry
// in the cycle after its read. A match ends the scan. A probe hit then passes
// through ST_MOVE_RD and ST_MOVE_WR, which move the last entry into the freed
// slot, and ST_OUT, which loads the output register. A load into a full set
// goes from the scan to ST_OUT, which loads the output register. Clear words
// and unused kinds are handled in the idle state. Loading the output register
// waits as long as it still holds a word that is not taken. A finished result
// sits in the output register while the next word is already accepted.
module set_intersection_filter
  import sif_pkg::*;
#(
  parameter int SET_DEPTH = SET_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sif_item_if.sink     item,
  sif_result_if.source result
);

  sif_cmd_t cmd;
  sif_sts_t sts;

  sif_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_kind  (item.kind),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sif_datapath #(
    .SET_DEPTH (SET_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_kind    (item.kind),
    .in_value   (item.value),
    .cmd        (cmd),
    .sts        (sts),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_value  (result.value_res),
    .res_status (result.status)
  );

endmodule

### rtl/sif_checker.sv
// Port-level assertions for the set intersection filter, bound to the top level.
// Depends on sif_pkg and set_intersection_filter.
module sif_checker
  import sif_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic [1:0]  item_kind,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] result_value,
  input logic        result_status
);

  // A stalled result word holds its contents.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_value) && $stable(result_status))
    else $error("result word changed while stalled");

  // A load or probe occupies the block for at least the next cycle.
  a_busy_after_lookup: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && ((item_kind == KIND_LOAD) || (item_kind == KIND_PROBE))
      |=> !item_ready)
    else $error("input accepted while a lookup is in progress");

  // A new result only appears at the end of a lookup.
  a_result_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared without a lookup");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind set_intersection_filter sif_checker u_sif_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .item_kind     (item.kind),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_value  (result.value_res),
  .result_status (result.status)
);
